@@ hw/rtl/dcc_pkg.sv @@
package dcc_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 16;
    localparam int WIDTH_W    = 12;
    localparam int ALPHA_W    = 9;
    localparam int CH_W       = 8;
    localparam int OCOL_W     = 11;
    localparam int FACT_W     = ALPHA_W + 1;
    localparam int PROD_W     = CH_W + FACT_W - 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ALPHA_MAX  = 256;
    localparam int ONE_Q8     = 256;
    localparam int HALF_Q8    = 128;
    localparam int CH_SAT     = 255;
    localparam int MIN_DIM    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              last;
    } t_pos;

    function automatic logic [CH_W-1:0] ch_max(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_pix pix_max(input t_pix a, input t_pix b);
        t_pix m;
        m.red   = ch_max(a.red, b.red);
        m.green = ch_max(a.green, b.green);
        m.blue  = ch_max(a.blue, b.blue);
        return m;
    endfunction

    // Q2.8 scale with round half up and saturation at full scale.
    function automatic logic [CH_W-1:0] scale_chan(input logic [CH_W-1:0]   p,
                                                   input logic [FACT_W-1:0] f);
        logic [PROD_W-1:0] q;
        logic [PROD_W-1:0] qr;
        q  = PROD_W'(p) * PROD_W'(f);
        qr = q + PROD_W'(HALF_Q8);
        if (q >= PROD_W'(CH_SAT * ONE_Q8)) begin
            return CH_W'(CH_SAT);
        end
        return qr[CH_W +: CH_W];
    endfunction

endpackage

@@ hw/rtl/dcc_line_buf.sv @@
module dcc_line_buf (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [dcc_pkg::COL_W-1:0] i_rd_addr,
    input  dcc_pkg::t_pix             i_px,
    input  logic                      i_up_we,
    input  logic [dcc_pkg::COL_W-1:0] i_up_addr,
    input  dcc_pkg::t_pix             i_up_data,
    output dcc_pkg::t_pix             o_up,
    output dcc_pkg::t_pix             o_mid
);
    import dcc_pkg::*;

    t_pix r_upper  [MAX_WIDTH];
    t_pix r_middle [MAX_WIDTH];
    t_pix r_up_q;
    t_pix r_mid_q;

    // The middle row is read and overwritten with the new pixel at the same edge.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mid_q             <= r_middle[i_rd_addr];
            r_middle[i_rd_addr] <= i_px;
        end
    end

    // The upper row takes the old middle entry when i_up_we is set.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up_q <= r_upper[i_rd_addr];
        end
        if (i_up_we) begin
            r_upper[i_up_addr] <= i_up_data;
        end
    end

    assign o_up  = r_up_q;
    assign o_mid = r_mid_q;

endmodule

@@ hw/rtl/dcc_window.sv @@
module dcc_window (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  dcc_pkg::t_pix i_up,
    input  dcc_pkg::t_pix i_mid,
    input  dcc_pkg::t_pix i_px,
    output dcc_pkg::t_pix o_win_max,
    output dcc_pkg::t_pix o_centre
);
    import dcc_pkg::*;

    // Each column of the window is kept only as its per-channel maximum,
    // plus the middle-row pixels needed for the centre.
    t_pix r_colmax [3];
    t_pix r_mid_prev;
    t_pix r_mid_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colmax[0] <= '0;
            r_colmax[1] <= '0;
            r_colmax[2] <= '0;
            r_mid_prev  <= '0;
            r_mid_cur   <= '0;
        end else if (i_shift) begin
            r_colmax[0] <= r_colmax[1];
            r_colmax[1] <= r_colmax[2];
            r_colmax[2] <= pix_max(pix_max(i_up, i_mid), i_px);
            r_mid_prev  <= r_mid_cur;
            r_mid_cur   <= i_mid;
        end
    end

    assign o_win_max = pix_max(pix_max(r_colmax[0], r_colmax[1]), r_colmax[2]);
    assign o_centre  = r_mid_prev;

endmodule

@@ hw/rtl/dcc_colorize.sv @@
module dcc_colorize (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  dcc_pkg::t_pix               i_win_max,
    input  dcc_pkg::t_pix               i_centre,
    input  logic [dcc_pkg::ALPHA_W-1:0] i_alpha,
    input  dcc_pkg::t_pos               i_pos,
    output dcc_pkg::t_pix               o_pix,
    output dcc_pkg::t_pos               o_pos
);
    import dcc_pkg::*;

    logic [ALPHA_W-1:0] alpha_eff;
    logic [FACT_W-1:0]  f_up;
    logic [FACT_W-1:0]  f_dn;
    logic [FACT_W-1:0]  f_red;
    logic [FACT_W-1:0]  f_green;
    logic [FACT_W-1:0]  f_blue;
    t_pix               n_pix;
    t_pix               r_pix;
    t_pos               r_pos;

    always_comb begin
        alpha_eff = (i_alpha > ALPHA_W'(ALPHA_MAX)) ? ALPHA_W'(ALPHA_MAX) : i_alpha;
        f_up      = FACT_W'(ONE_Q8) + FACT_W'(alpha_eff);
        f_dn      = FACT_W'(ONE_Q8) - FACT_W'(alpha_eff);
        f_red     = f_dn;
        f_green   = f_dn;
        f_blue    = f_dn;
        // Ties go to red first, then green.
        priority if (i_win_max.red >= i_win_max.green && i_win_max.red >= i_win_max.blue) begin
            f_red = f_up;
        end else if (i_win_max.green >= i_win_max.blue) begin
            f_green = f_up;
        end else begin
            f_blue = f_up;
        end
        n_pix.red   = scale_chan(i_centre.red, f_red);
        n_pix.green = scale_chan(i_centre.green, f_green);
        n_pix.blue  = scale_chan(i_centre.blue, f_blue);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pix <= n_pix;
            r_pos <= i_pos;
        end
    end

    assign o_pix = r_pix;
    assign o_pos = r_pos;

endmodule

@@ hw/rtl/dominant_channel_colorize_3x3.sv @@
// Dominant-channel colorize over a 3x3 window.
// Pixels enter in raster order on the s_axis channel, one transfer per pixel.
// Each interior centre pixel leaves on m_axis with its row and column; the
// dominant channel of the window is boosted by alpha and the others reduced.
// Border pixels give no output; tlast marks the last interior pixel of a frame.
// Configuration (alpha, width, height) is written through i_cfg_*. The user must
// write it only while idle; the block leaves enforcing this to the user. The result
// for centre (r-1, c-1) follows pixel (r, c) through the line-store read at the
// accepting edge, the window update and the output register; a stall may come between.
// Throughput: one pixel per cycle while the receiver keeps m_axis_tready high.
// The output register lets a new pixel be taken while a result waits; when the
// receiver stalls, back-pressure reaches s_axis_tready once the three stages fill.
// Reset clears the row and column counters, the window and the pipeline, and
// loads alpha 0, width 640, height 480. The line stores are not cleared: every
// entry is written by a row before it is read for a later one.
module dominant_channel_colorize_3x3 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // in_red, in_green, in_blue
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [55:0]                    m_axis_tdata,  // out_red, out_green, out_blue,
                                                          // out_row, out_col, zero pad
    output logic                           m_axis_tlast   // frame_last
);
    import dcc_pkg::*;

    logic [ALPHA_W-1:0] r_alpha;
    logic [WIDTH_W-1:0] r_width;
    logic [ROW_W-1:0]   r_height;
    logic [COL_W-1:0]   r_col_cnt;
    logic [ROW_W-1:0]   r_row_cnt;
    logic [COL_W-1:0]   n_col_cnt;
    logic [ROW_W-1:0]   n_row_cnt;
    logic [WIDTH_W-1:0] w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic               last_col;
    logic               last_row;
    logic               accept;

    logic               r_s1_v;
    logic               r_s1_res;
    logic [COL_W-1:0]   r_s1_addr;
    t_pix               r_s1_px;
    t_pos               r_s1_pos;
    logic               r_s2_v;
    t_pos               r_s2_pos;
    logic               r_o_v;

    logic               out_free;
    logic               s2_free;
    logic               s1_adv;
    logic               out_load;

    t_pix               in_px;
    t_pix               up_px;
    t_pix               mid_px;
    t_pix               win_max;
    t_pix               centre;
    t_pix               o_pix;
    t_pos               o_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= '0;
            r_width  <= WIDTH_W'(640);
            r_height <= ROW_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALPHA:  r_alpha  <= i_cfg_data[ALPHA_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        priority if (r_width < WIDTH_W'(MIN_DIM)) begin
            w_eff = WIDTH_W'(MIN_DIM);
        end else if (r_width > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        h_eff    = (r_height < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : r_height;
        last_col = WIDTH_W'(r_col_cnt) >= (w_eff - WIDTH_W'(1));
        last_row = r_row_cnt >= (h_eff - ROW_W'(1));
        if (last_col) begin
            n_col_cnt = '0;
            n_row_cnt = last_row ? '0 : (r_row_cnt + ROW_W'(1));
        end else begin
            n_col_cnt = r_col_cnt + COL_W'(1);
            n_row_cnt = r_row_cnt;
        end
    end

    assign in_px.red   = s_axis_tdata[7:0];
    assign in_px.green = s_axis_tdata[15:8];
    assign in_px.blue  = s_axis_tdata[23:16];

    // Handshake chain: each stage frees when the one after it can take its contents.
    assign out_free      = !r_o_v || m_axis_tready;
    assign s2_free       = !r_s2_v || out_free;
    assign s1_adv        = r_s1_v && s2_free;
    assign out_load      = r_s2_v && out_free;
    assign s_axis_tready = !r_s1_v || s2_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_s1_v    <= 1'b0;
            r_s1_res  <= 1'b0;
            r_s2_v    <= 1'b0;
            r_o_v     <= 1'b0;
        end else begin
            if (accept) begin
                r_col_cnt <= n_col_cnt;
                r_row_cnt <= n_row_cnt;
                r_s1_res  <= (r_row_cnt >= ROW_W'(2)) && (r_col_cnt >= COL_W'(2));
            end
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_v <= r_s1_res;
            end else if (out_free) begin
                r_s2_v <= 1'b0;
            end
            if (out_load) begin
                r_o_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr     <= r_col_cnt;
            r_s1_px       <= in_px;
            r_s1_pos.row  <= r_row_cnt - ROW_W'(1);
            r_s1_pos.col  <= OCOL_W'(r_col_cnt - COL_W'(1));
            r_s1_pos.last <= last_col && last_row;
        end
        if (s1_adv) begin
            r_s2_pos <= r_s1_pos;
        end
    end

    dcc_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col_cnt),
        .i_px      (in_px),
        .i_up_we   (s1_adv),
        .i_up_addr (r_s1_addr),
        .i_up_data (mid_px),
        .o_up      (up_px),
        .o_mid     (mid_px)
    );

    dcc_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (s1_adv),
        .i_up      (up_px),
        .i_mid     (mid_px),
        .i_px      (r_s1_px),
        .o_win_max (win_max),
        .o_centre  (centre)
    );

    dcc_colorize u_colorize (
        .i_clk     (i_clk),
        .i_load    (out_load),
        .i_win_max (win_max),
        .i_centre  (centre),
        .i_alpha   (r_alpha),
        .i_pos     (r_s2_pos),
        .o_pix     (o_pix),
        .o_pos     (o_pos)
    );

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {5'b0, o_pos.col, o_pos.row, o_pix.blue, o_pix.green, o_pix.red};
    assign m_axis_tlast  = o_pos.last;

    // A pending result must not be dropped while the output register is full.
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && !out_free) |=> r_s2_v)
        else $error("pending result lost under back-pressure");

    // An interior pixel must be marked as producing a result.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_col_cnt >= COL_W'(2) && r_row_cnt >= ROW_W'(2)) |=> (r_s1_v && r_s1_res))
        else $error("interior pixel not flagged for output");

    // A stalled first stage keeps its line-store address for the upper write.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s2_free) |=> (r_s1_v && $stable(r_s1_addr)))
        else $error("first stage changed while stalled");

    // Results are interior, so neither coordinate can be zero.
    a_interior_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> (o_pos.row != '0 && o_pos.col != '0))
        else $error("border coordinate on output");

endmodule

@@ bench/dominant_channel_colorize_3x3_tb.sv @@
module dominant_channel_colorize_3x3_tb;
    import dcc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 1000;
    localparam int WIDE_PIXELS   = 150;
    localparam int DIR_ROWS      = 25;

    typedef struct packed {
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              last;
    } centre_result_t;

    typedef enum logic {
        ROW_PIX,
        ROW_CFG
    } row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_pix                  px;
        logic                  has_typed;
        centre_result_t        typed;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;  // in_red, in_green, in_blue
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [55:0]           m_axis_tdata;        // out_red, out_green, out_blue,
                                                // out_row, out_col, zero pad
    logic                  m_axis_tlast;        // frame_last

    // Mirror of the block: line stores, window, raster position and registers.
    t_pix               upper_row_mem [MAX_WIDTH];
    t_pix               middle_row_mem [MAX_WIDTH];
    t_pix               window [9];
    int unsigned        next_col;
    int unsigned        next_row;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;

    centre_result_t expected_pixels [$];
    dir_row_t       directed_rows [DIR_ROWS];

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned cycle_count    = 0;
    int unsigned fail_count     = 0;
    int unsigned pixels_sent    = 0;
    int unsigned results_seen   = 0;
    int unsigned reg_writes     = 0;
    int unsigned phase_count    = 0;

    dominant_channel_colorize_3x3 i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_width();
        if (width_reg < MIN_DIM) return MIN_DIM;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg < MIN_DIM) return MIN_DIM;
        return height_reg;
    endfunction

    function automatic logic [CH_W-1:0] scaled_channel(input logic [CH_W-1:0] p,
                                                       input int unsigned f);
        int unsigned q;
        q = p * f;
        if (q >= CH_SAT * ONE_Q8) return CH_W'(CH_SAT);
        return CH_W'((q + HALF_Q8) >> 8);
    endfunction

    // Advances the mirror by one pixel; returns 1 when an interior centre completes.
    function automatic bit colorize_pixel(input t_pix px, output centre_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned a;
        int unsigned c;
        int unsigned r;
        int unsigned fr;
        int unsigned fg;
        int unsigned fb;
        int          i;
        t_pix        up;
        t_pix        mid;
        logic [CH_W-1:0] mr;
        logic [CH_W-1:0] mg;
        logic [CH_W-1:0] mb;
        bit          last_col;
        bit          last_row;
        bit          produced;
        w = eff_width();
        h = eff_height();
        a = (alpha_reg > ALPHA_MAX) ? ALPHA_MAX : alpha_reg;
        c = next_col;
        r = next_row;
        up  = upper_row_mem[c];
        mid = middle_row_mem[c];
        upper_row_mem[c]  = mid;
        middle_row_mem[c] = px;
        for (i = 0; i < 3; i++) begin
            window[i*3]   = window[i*3+1];
            window[i*3+1] = window[i*3+2];
        end
        window[2] = up;
        window[5] = mid;
        window[8] = px;
        last_col = (c >= w - 1);
        last_row = (r >= h - 1);
        produced = 1'b0;
        res      = '0;
        if (r >= 2 && c >= 2) begin
            mr = '0;
            mg = '0;
            mb = '0;
            for (i = 0; i < 9; i++) begin
                if (window[i].red > mr) mr = window[i].red;
                if (window[i].green > mg) mg = window[i].green;
                if (window[i].blue > mb) mb = window[i].blue;
            end
            // Red wins ties with either channel, green wins a tie with blue.
            fr = ONE_Q8 - a;
            fg = fr;
            fb = fr;
            if (mr >= mg && mr >= mb) begin
                fr = ONE_Q8 + a;
            end else if (mg >= mb) begin
                fg = ONE_Q8 + a;
            end else begin
                fb = ONE_Q8 + a;
            end
            res.red   = scaled_channel(window[4].red, fr);
            res.green = scaled_channel(window[4].green, fg);
            res.blue  = scaled_channel(window[4].blue, fb);
            res.row   = ROW_W'(r - 1);
            res.col   = OCOL_W'(c - 1);
            res.last  = last_col && last_row;
            produced  = 1'b1;
        end
        if (last_col) begin
            next_col = 0;
            next_row = last_row ? 0 : ((r + 1) & 32'hFFFF);
        end else begin
            next_col = c + 1;
        end
        return produced;
    endfunction

    function automatic dir_row_t cfg_row(input t_cfg_idx idx, input int unsigned val);
        dir_row_t d;
        d         = '0;
        d.kind    = ROW_CFG;
        d.reg_idx = idx;
        d.reg_val = CFG_DATA_W'(val);
        return d;
    endfunction

    function automatic dir_row_t pix_row(input int unsigned r, input int unsigned g,
                                         input int unsigned b);
        dir_row_t d;
        d          = '0;
        d.kind     = ROW_PIX;
        d.px.red   = CH_W'(r);
        d.px.green = CH_W'(g);
        d.px.blue  = CH_W'(b);
        return d;
    endfunction

    // A pixel whose result is plain from the window: typed in, not predicted.
    function automatic dir_row_t checked_row(input int unsigned r, input int unsigned g,
                                             input int unsigned b, input int unsigned er,
                                             input int unsigned eg, input int unsigned eb,
                                             input int unsigned erow,
                                             input int unsigned ecol, input bit elast);
        dir_row_t d;
        d                = pix_row(r, g, b);
        d.has_typed      = 1'b1;
        d.typed.red      = CH_W'(er);
        d.typed.green    = CH_W'(eg);
        d.typed.blue     = CH_W'(eb);
        d.typed.row      = ROW_W'(erow);
        d.typed.col      = OCOL_W'(ecol);
        d.typed.last     = elast;
        return d;
    endfunction

    function automatic logic [CH_W-1:0] extreme_channel();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pix random_pixel();
        t_pix            px;
        logic [CH_W-1:0] v;
        case ($urandom_range(0, 3))
            0: px = 24'($urandom);
            1: begin
                px.red   = extreme_channel();
                px.green = extreme_channel();
                px.blue  = extreme_channel();
            end
            2: begin
                v  = CH_W'($urandom_range(0, 255));
                px = {v, v, v};
            end
            default: begin
                // Dark pixels make equal channel maxima common.
                px.red   = CH_W'($urandom_range(0, 15));
                px.green = CH_W'($urandom_range(0, 15));
                px.blue  = CH_W'($urandom_range(0, 15));
            end
        endcase
        return px;
    endfunction

    task automatic set_idle_mode(input int unsigned mode);
        case (mode % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
            default: begin src_idle_pct = 9; sink_stall_pct = 9; end
        endcase
    endtask

    task automatic send_pixel(input t_pix px, input bit use_typed,
                              input centre_result_t typed_res);
        centre_result_t res;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {px.blue, px.green, px.red};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pixels_sent++;
        if (colorize_pixel(px, res)) begin
            expected_pixels.push_back(use_typed ? typed_res : res);
        end
    endtask

    task automatic send_random_pixels(input int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++) send_pixel(random_pixel(), 1'b0, '0);
    endtask

    task automatic finish_frame();
        while (next_col != 0 || next_row != 0) send_pixel(random_pixel(), 1'b0, '0);
    endtask

    // Holds the sender off until every outstanding result has been received.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_ALPHA:  alpha_reg  = val[ALPHA_W-1:0];
            CFG_WIDTH:  width_reg  = val[WIDTH_W-1:0];
            CFG_HEIGHT: height_reg = val[ROW_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // One random setting: starts at a frame boundary, so the width may grow here.
    task automatic run_random_phase();
        int unsigned alpha_val;
        int unsigned area;
        case ($urandom_range(0, 4))
            0:       alpha_val = 0;
            1:       alpha_val = ALPHA_MAX;
            2, 3:    alpha_val = $urandom_range(0, ALPHA_MAX);
            default: alpha_val = $urandom_range(0, 16'hFFFF);
        endcase
        write_reg(CFG_ALPHA, CFG_DATA_W'(alpha_val));
        if ($urandom_range(0, 4) == 0) begin
            write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(0, MIN_DIM - 1)));
        end else begin
            write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(MIN_DIM, 12)));
        end
        write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(0, 7)));
        set_idle_mode(phase_count);
        phase_count++;
        area = eff_width() * eff_height();
        send_random_pixels($urandom_range(1, 2 * area));
        if ($urandom_range(0, 2) == 0) begin
            // Mid-frame change: the width may only shrink, the height may move freely.
            drain_results();
            write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(MIN_DIM, eff_width())));
            write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(MIN_DIM, 8)));
        end
        finish_frame();
        drain_results();
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        centre_result_t got;
        centre_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.red   = m_axis_tdata[7:0];
            got.green = m_axis_tdata[15:8];
            got.blue  = m_axis_tdata[23:16];
            got.row   = m_axis_tdata[39:24];
            got.col   = m_axis_tdata[50:40];
            got.last  = m_axis_tlast;
            results_seen++;
            if (expected_pixels.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: rgb %0d %0d %0d row %0d col %0d last %0b",
                             got.red, got.green, got.blue, got.row, got.col, got.last);
                end
            end else begin
                want = expected_pixels.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.row !== want.row ||
                    got.col !== want.col || got.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: expected rgb %0d %0d %0d row %0d col %0d last %0b",
                                 want.red, want.green, want.blue, want.row, want.col,
                                 want.last);
                        $display("          actual   rgb %0d %0d %0d row %0d col %0d last %0b",
                                 got.red, got.green, got.blue, got.row, got.col, got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pixels.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int          i;
        int unsigned random_base;
        for (i = 0; i < MAX_WIDTH; i++) begin
            upper_row_mem[i]  = '0;
            middle_row_mem[i] = '0;
        end
        for (i = 0; i < 9; i++) window[i] = '0;
        next_col   = 0;
        next_row   = 0;
        alpha_reg  = '0;
        width_reg  = WIDTH_W'(640);
        height_reg = ROW_W'(480);

        // Out-of-range sizes clamp to 3x3 and alpha above range saturates at full
        // strength, so unboosted channels fall to zero and the typed values follow.
        directed_rows = '{
            cfg_row(CFG_WIDTH, 1),
            cfg_row(CFG_HEIGHT, 0),
            cfg_row(CFG_ALPHA, 16'h01FF),
            pix_row(255, 255, 255), pix_row(0, 0, 0), pix_row(255, 0, 0),
            pix_row(0, 255, 0), pix_row(100, 100, 100), pix_row(0, 0, 255),
            pix_row(0, 0, 0), pix_row(255, 255, 255),
            checked_row(1, 2, 3, 200, 0, 0, 1, 1, 1'b1),
            cfg_row(CFG_WIDTH, 4),
            pix_row(0, 0, 0), pix_row(5, 5, 5), pix_row(0, 0, 0), pix_row(0, 0, 0),
            pix_row(0, 0, 0), pix_row(10, 200, 200), pix_row(40, 60, 90),
            pix_row(0, 0, 250),
            pix_row(0, 0, 0), pix_row(0, 0, 0),
            checked_row(0, 0, 0, 0, 255, 0, 1, 1, 1'b0),
            checked_row(0, 0, 0, 0, 0, 180, 1, 2, 1'b1)
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idle_mode(3);
        for (i = 0; i < DIR_ROWS; i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain_results();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end else begin
                send_pixel(directed_rows[i].px, directed_rows[i].has_typed,
                           directed_rows[i].typed);
            end
        end

        // A long first row at the clamped widest setting, cut short by a narrow
        // width, then a very tall frame cut short by a low height.
        drain_results();
        write_reg(CFG_WIDTH, 16'hFFFF);
        write_reg(CFG_HEIGHT, 16'd3);
        write_reg(CFG_ALPHA, CFG_DATA_W'($urandom_range(1, ALPHA_MAX - 1)));
        send_random_pixels(WIDE_PIXELS);
        drain_results();
        write_reg(CFG_WIDTH, 16'd3);
        finish_frame();
        drain_results();
        write_reg(CFG_HEIGHT, 16'hFFFF);
        set_idle_mode(1);
        send_random_pixels(90);
        drain_results();
        write_reg(CFG_HEIGHT, 16'd5);
        finish_frame();
        drain_results();

        random_base = pixels_sent;
        while (pixels_sent - random_base < RANDOM_PIXELS) run_random_phase();

        drain_results();
        $display("Run covered %0d pixel transfers and %0d result transfers in %0d cycles,",
                 pixels_sent, results_seen, cycle_count);
        $display("with %0d register writes over %0d random settings and all idle mixes.",
                 reg_writes, phase_count);
        if (fail_count == 0 && expected_pixels.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d failures, %0d results never arrived",
                     fail_count, expected_pixels.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ dominant_channel_colorize_3x3.f @@
hw/rtl/dcc_pkg.sv
hw/rtl/dcc_line_buf.sv
hw/rtl/dcc_window.sv
hw/rtl/dcc_colorize.sv
hw/rtl/dominant_channel_colorize_3x3.sv
bench/dominant_channel_colorize_3x3_tb.sv
